/* hw/rtl/sbsk_pkg.sv */
`default_nettype none
// ============================================================================
// sbsk_pkg
// Shared types and constants for the scaled, mirrored, color-keyed sprite
// blitter: register codes, the configuration bundle and the item sideband.
// ============================================================================

package sbsk_pkg;

    // Default store geometry; the top level may override it by parameter.
    localparam int MAX_SPRITE_W_DEF = 128;
    localparam int MAX_SPRITE_H_DEF = 128;

    // Transparent color key and the fixed-point position of the zoom factor.
    localparam logic [7:0] KEY_COLOR  = 8'hFF;
    localparam int         ZOOM_SHIFT = 8;

    // Divider geometry: an 11 bit offset scaled by 256 over an 11 bit zoom.
    localparam int OFS_W     = 11;
    localparam int ZOOM_W    = 11;
    localparam int DIV_NUM_W = OFS_W + ZOOM_SHIFT;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_SPRITE_WIDTH  = 3'd2,
        REG_SPRITE_HEIGHT = 3'd3,
        REG_MIRROR_MODE   = 3'd4,
        REG_ZOOM_FACTOR   = 3'd5,
        REG_SCREEN_WIDTH  = 3'd6,
        REG_SCREEN_HEIGHT = 3'd7
    } reg_idx_t;

    // Configuration as seen by the datapath. The origins are two's complement.
    typedef struct packed {
        logic [10:0]       origin_x;
        logic [10:0]       origin_y;
        logic [7:0]        sprite_width;
        logic [7:0]        sprite_height;
        logic              mirror_mode;
        logic [ZOOM_W-1:0] zoom_factor;
        logic [9:0]        screen_width;
        logic [9:0]        screen_height;
    } cfg_t;

    // Sideband that travels with an item from the geometry stages onward.
    typedef struct packed {
        logic       is_draw;
        logic       in_rect;
        logic [9:0] cx;
        logic [9:0] cy;
        logic [7:0] pix;
        logic [7:0] w;
        logic [7:0] h;
    } item_t;

endpackage

`default_nettype wire

/* hw/rtl/sbsk_cfg_regs.sv */
`default_nettype none
// ============================================================================
// sbsk_cfg_regs
// Configuration register file; every write transaction completes at once.
// ============================================================================

module sbsk_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sbsk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sbsk_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sbsk_pkg::cfg_t                        cfg
);
    import sbsk_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_ORIGIN_X:      cfg_next.origin_x      = cfg_data[10:0];
                REG_ORIGIN_Y:      cfg_next.origin_y      = cfg_data[10:0];
                REG_SPRITE_WIDTH:  cfg_next.sprite_width  = cfg_data[7:0];
                REG_SPRITE_HEIGHT: cfg_next.sprite_height = cfg_data[7:0];
                REG_MIRROR_MODE:   cfg_next.mirror_mode   = cfg_data[0];
                REG_ZOOM_FACTOR:   cfg_next.zoom_factor   = cfg_data[ZOOM_W-1:0];
                REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[9:0];
                REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[9:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= 11'd0;
            cfg_reg.origin_y      <= 11'd0;
            cfg_reg.sprite_width  <= 8'd128;
            cfg_reg.sprite_height <= 8'd128;
            cfg_reg.mirror_mode   <= 1'b0;
            cfg_reg.zoom_factor   <= 11'd256;
            cfg_reg.screen_width  <= 10'd320;
            cfg_reg.screen_height <= 10'd200;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/sbsk_geom.sv */
`default_nettype none
// ============================================================================
// sbsk_geom
// Two geometry stages: scaled sprite size and origin offsets, then the
// clipped-rectangle test and the scaled numerators for the divider.
// ============================================================================

module sbsk_geom #(
    parameter int MAX_SPRITE_W = sbsk_pkg::MAX_SPRITE_W_DEF,
    parameter int MAX_SPRITE_H = sbsk_pkg::MAX_SPRITE_H_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            adv,
    input  wire sbsk_pkg::cfg_t                  cfg,
    input  wire logic                            in_valid,
    input  wire logic                            op,
    input  wire logic [9:0]                      coord_x,
    input  wire logic [9:0]                      coord_y,
    input  wire logic [7:0]                      pixel_in,
    output logic                                 out_valid,
    output sbsk_pkg::item_t                      out_item,
    output logic [sbsk_pkg::DIV_NUM_W-1:0]       out_num_x,
    output logic [sbsk_pkg::DIV_NUM_W-1:0]       out_num_y
);
    import sbsk_pkg::*;

    localparam logic [10:0] MAX_W11 = 11'(MAX_SPRITE_W);
    localparam logic [10:0] MAX_H11 = 11'(MAX_SPRITE_H);
    localparam int          PROD_W  = ZOOM_W + 8;

    // Stage one registers.
    logic               g1_v_reg;
    item_t              g1_item_reg, g1_item_next;
    logic [OFS_W:0]     g1_ox_reg, g1_ox_next;
    logic [OFS_W:0]     g1_oy_reg, g1_oy_next;
    logic [10:0]        g1_dw_reg, g1_dw_next;
    logic [10:0]        g1_dh_reg, g1_dh_next;

    // Stage two registers.
    logic                 g2_v_reg;
    item_t                g2_item_reg, g2_item_next;
    logic [DIV_NUM_W-1:0] g2_nx_reg, g2_nx_next;
    logic [DIV_NUM_W-1:0] g2_ny_reg, g2_ny_next;

    logic [PROD_W-1:0] prod_w;
    logic [PROD_W-1:0] prod_h;
    logic              in_x;
    logic              in_y;

    always_comb
    begin
        g1_item_next.is_draw = op;
        g1_item_next.in_rect = 1'b0;
        g1_item_next.cx      = coord_x;
        g1_item_next.cy      = coord_y;
        g1_item_next.pix     = pixel_in;
        // Sizes above the store geometry saturate to it.
        g1_item_next.w = ({3'b000, cfg.sprite_width} > MAX_W11) ? MAX_W11[7:0]
                                                                : cfg.sprite_width;
        g1_item_next.h = ({3'b000, cfg.sprite_height} > MAX_H11) ? MAX_H11[7:0]
                                                                 : cfg.sprite_height;

        prod_w = PROD_W'(cfg.zoom_factor) * PROD_W'(g1_item_next.w);
        prod_h = PROD_W'(cfg.zoom_factor) * PROD_W'(g1_item_next.h);
        g1_dw_next = prod_w[PROD_W-1:ZOOM_SHIFT];
        g1_dh_next = prod_h[PROD_W-1:ZOOM_SHIFT];

        // Offsets from the unclipped origin, 12 bit two's complement.
        g1_ox_next = {2'b00, coord_x} - {cfg.origin_x[10], cfg.origin_x};
        g1_oy_next = {2'b00, coord_y} - {cfg.origin_y[10], cfg.origin_y};
    end

    always_comb
    begin
        // Left and top clipping reduce to a non-negative offset because the
        // screen coordinate itself is never negative.
        in_x = !g1_ox_reg[OFS_W] && (g1_ox_reg[OFS_W-1:0] < g1_dw_reg)
               && (g1_item_reg.cx < cfg.screen_width);
        in_y = !g1_oy_reg[OFS_W] && (g1_oy_reg[OFS_W-1:0] < g1_dh_reg)
               && (g1_item_reg.cy < cfg.screen_height);

        g2_item_next         = g1_item_reg;
        g2_item_next.in_rect = g1_item_reg.is_draw && in_x && in_y
                               && (cfg.zoom_factor != '0);
        g2_nx_next = {g1_ox_reg[OFS_W-1:0], ZOOM_SHIFT'(0)};
        g2_ny_next = {g1_oy_reg[OFS_W-1:0], ZOOM_SHIFT'(0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g1_v_reg <= 1'b0;
            g2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            g1_v_reg <= in_valid;
            g2_v_reg <= g1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g1_item_reg <= g1_item_next;
            g1_ox_reg   <= g1_ox_next;
            g1_oy_reg   <= g1_oy_next;
            g1_dw_reg   <= g1_dw_next;
            g1_dh_reg   <= g1_dh_next;
            g2_item_reg <= g2_item_next;
            g2_nx_reg   <= g2_nx_next;
            g2_ny_reg   <= g2_ny_next;
        end
    end

    assign out_valid = g2_v_reg;
    assign out_item  = g2_item_reg;
    assign out_num_x = g2_nx_reg;
    assign out_num_y = g2_ny_reg;

endmodule

`default_nettype wire

/* hw/rtl/sbsk_div.sv */
`default_nettype none
// ============================================================================
// sbsk_div
// Pipelined restoring divider, one quotient bit per stage, with an X and a
// Y lane sharing the zoom factor as divisor and carrying the item sideband.
// ============================================================================

module sbsk_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            adv,
    input  wire logic [sbsk_pkg::ZOOM_W-1:0]     divisor,
    input  wire logic                            in_valid,
    input  wire sbsk_pkg::item_t                 in_item,
    input  wire logic [sbsk_pkg::DIV_NUM_W-1:0]  in_num_x,
    input  wire logic [sbsk_pkg::DIV_NUM_W-1:0]  in_num_y,
    output logic                                 out_valid,
    output sbsk_pkg::item_t                      out_item,
    output logic [sbsk_pkg::DIV_NUM_W-1:0]       out_quo_x,
    output logic [sbsk_pkg::DIV_NUM_W-1:0]       out_quo_y
);
    import sbsk_pkg::*;

    localparam int NW = DIV_NUM_W;
    localparam int RW = ZOOM_W;

    // Partial remainder and the numerator word that fills with quotient bits.
    typedef struct packed {
        logic [RW-1:0] rem;
        logic [NW-1:0] nq;
    } dstep_t;

    function automatic dstep_t div_step(input dstep_t cur, input logic [RW-1:0] d);
        dstep_t      res;
        logic [RW:0] trial;
        logic        qbit;
        trial = {cur.rem, cur.nq[NW-1]};
        qbit  = (trial >= {1'b0, d});
        if (qbit)
        begin
            trial = trial - {1'b0, d};
        end
        res.rem = trial[RW-1:0];
        res.nq  = {cur.nq[NW-2:0], qbit};
        return res;
    endfunction

    logic   v_reg    [NW];
    item_t  item_reg [NW];
    dstep_t x_reg    [NW];
    dstep_t y_reg    [NW];
    dstep_t x_next   [NW];
    dstep_t y_next   [NW];

    always_comb
    begin
        x_next[0] = div_step('{rem: '0, nq: in_num_x}, divisor);
        y_next[0] = div_step('{rem: '0, nq: in_num_y}, divisor);
        for (int s = 1; s < NW; s++)
        begin
            x_next[s] = div_step(x_reg[s-1], divisor);
            y_next[s] = div_step(y_reg[s-1], divisor);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NW; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NW; s++)
            begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg[0] <= in_item;
            for (int s = 1; s < NW; s++)
            begin
                item_reg[s] <= item_reg[s-1];
            end
            for (int s = 0; s < NW; s++)
            begin
                x_reg[s] <= x_next[s];
                y_reg[s] <= y_next[s];
            end
        end
    end

    assign out_valid = v_reg[NW-1];
    assign out_item  = item_reg[NW-1];
    assign out_quo_x = x_reg[NW-1].nq;
    assign out_quo_y = y_reg[NW-1].nq;

endmodule

`default_nettype wire

/* hw/rtl/sbsk_fetch.sv */
`default_nettype none
// ============================================================================
// sbsk_fetch
// Back end: clamps and mirrors the source pixel, forms the store address,
// accesses the sprite store and registers the keyed result.
// ============================================================================

module sbsk_fetch #(
    parameter int MAX_SPRITE_W = sbsk_pkg::MAX_SPRITE_W_DEF,
    parameter int MAX_SPRITE_H = sbsk_pkg::MAX_SPRITE_H_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            adv,
    input  wire sbsk_pkg::cfg_t                  cfg,
    input  wire logic                            in_valid,
    input  wire sbsk_pkg::item_t                 in_item,
    input  wire logic [sbsk_pkg::DIV_NUM_W-1:0]  in_quo_x,
    input  wire logic [sbsk_pkg::DIV_NUM_W-1:0]  in_quo_y,
    output logic                                 out_valid,
    output logic                                 write_enable,
    output logic [7:0]                           pixel_out,
    output logic                                 inside_rect
);
    import sbsk_pkg::*;

    localparam int          DEPTH   = MAX_SPRITE_W * MAX_SPRITE_H;
    localparam int          AW      = $clog2(DEPTH);
    localparam int          MW      = 21;
    localparam logic [10:0] MAX_W11 = 11'(MAX_SPRITE_W);
    localparam logic [10:0] MAX_H11 = 11'(MAX_SPRITE_H);

    // Stage one: source column and row.
    logic       f1_v_reg;
    logic       f1_inside_reg, f1_inside_next;
    logic       f1_wr_reg, f1_wr_next;
    logic [9:0] f1_col_reg, f1_col_next;
    logic [9:0] f1_row_reg, f1_row_next;
    logic [7:0] f1_pix_reg;

    // Stage two: store address.
    logic          f2_v_reg;
    logic          f2_inside_reg;
    logic          f2_wr_reg;
    logic [AW-1:0] f2_addr_reg, f2_addr_next;
    logic [7:0]    f2_pix_reg;

    // Stage three: store access.
    logic       f3_v_reg;
    logic       f3_inside_reg;
    logic [7:0] rd_data_reg;
    logic [7:0] store_reg [DEPTH];

    // Stage four: result.
    logic       out_valid_reg;
    logic       write_enable_reg, write_enable_next;
    logic [7:0] pixel_out_reg, pixel_out_next;
    logic       inside_rect_reg;

    logic [7:0] w_m1;
    logic [7:0] h_m1;
    logic [7:0] sx_clamp;
    logic [7:0] sy_clamp;
    logic [7:0] sx;

    always_comb
    begin
        w_m1     = in_item.w - 8'd1;
        h_m1     = in_item.h - 8'd1;
        sx_clamp = (in_quo_x >= DIV_NUM_W'(in_item.w)) ? w_m1 : in_quo_x[7:0];
        sy_clamp = (in_quo_y >= DIV_NUM_W'(in_item.h)) ? h_m1 : in_quo_y[7:0];
        sx       = cfg.mirror_mode ? (w_m1 - sx_clamp) : sx_clamp;

        f1_inside_next = in_item.in_rect;
        // Loads outside the store geometry are dropped.
        f1_wr_next     = !in_item.is_draw && ({1'b0, in_item.cx} < MAX_W11)
                         && ({1'b0, in_item.cy} < MAX_H11);
        f1_col_next    = in_item.is_draw ? {2'b00, sx} : in_item.cx;
        f1_row_next    = in_item.is_draw ? {2'b00, sy_clamp} : in_item.cy;
    end

    always_comb
    begin
        f2_addr_next = AW'(MW'(f1_row_reg) * MW'(MAX_SPRITE_W) + MW'(f1_col_reg));
    end

    always_comb
    begin
        write_enable_next = f3_inside_reg && (rd_data_reg != KEY_COLOR);
        pixel_out_next    = f3_inside_reg ? rd_data_reg : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg      <= 1'b0;
            f2_v_reg      <= 1'b0;
            f3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f1_v_reg      <= in_valid;
            f2_v_reg      <= f1_v_reg;
            f3_v_reg      <= f2_v_reg;
            out_valid_reg <= f3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_inside_reg    <= f1_inside_next;
            f1_wr_reg        <= f1_wr_next;
            f1_col_reg       <= f1_col_next;
            f1_row_reg       <= f1_row_next;
            f1_pix_reg       <= in_item.pix;
            f2_inside_reg    <= f1_inside_reg;
            f2_wr_reg        <= f1_wr_reg;
            f2_addr_reg      <= f2_addr_next;
            f2_pix_reg       <= f1_pix_reg;
            f3_inside_reg    <= f2_inside_reg;
            write_enable_reg <= write_enable_next;
            pixel_out_reg    <= pixel_out_next;
            inside_rect_reg  <= f3_inside_reg;
        end
    end

    // Loads and draws meet the store at the same stage, so program order
    // between them is kept without any forwarding.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (f2_v_reg && f2_wr_reg)
            begin
                store_reg[f2_addr_reg] <= f2_pix_reg;
            end
            rd_data_reg <= store_reg[f2_addr_reg];
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = write_enable_reg;
    assign pixel_out    = pixel_out_reg;
    assign inside_rect  = inside_rect_reg;

endmodule

`default_nettype wire

/* hw/rtl/sprite_blit_scale_mirror_key_unit.sv */
`default_nettype none
// ============================================================================
// sprite_blit_scale_mirror_key_unit
// Indexed sprite blitter with zoom, horizontal mirror and transparent key,
// answering one screen pixel per transaction.
// ============================================================================
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+---------------------------------
//   in      | into      | in_valid / in_stall  | op, coord_x, coord_y, pixel_in
//   out     | out of    | out_valid / out_stall| write_enable, pixel_out,
//           |           |                      | inside_rect
//   cfg     | into      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One transaction is accepted per clock unless the pipeline is frozen; each
// gives exactly one result transaction after two geometry stages, nineteen
// divider stages (one quotient bit each for ox*256/zoom and oy*256/zoom)
// and four back-end stages around the single-port sprite store.
// All stages advance together; while the result register holds an untaken
// result and out_stall is high, the whole pipeline freezes and in_stall is
// raised. rst_n clears the valid bits and loads the configuration defaults;
// the sprite store has no reset and needs no clearing pass.
//
// Loads (op 0) write one store entry at row*MAX_SPRITE_W+col; draws (op 1)
// test the clipped, scaled rectangle and fetch the mapped sprite pixel. The
// user must write configuration only while idle; the block does not enforce it.
// ============================================================================

module sprite_blit_scale_mirror_key_unit #(
    parameter int MAX_SPRITE_W = sbsk_pkg::MAX_SPRITE_W_DEF,
    parameter int MAX_SPRITE_H = sbsk_pkg::MAX_SPRITE_H_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Item input channel.
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic                             op,
    input  wire logic [9:0]                       coord_x,
    input  wire logic [9:0]                       coord_y,
    input  wire logic [7:0]                       pixel_in,
    // Result channel.
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  write_enable,
    output logic [7:0]                            pixel_out,
    output logic                                  inside_rect,
    // Configuration write channel.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sbsk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sbsk_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sbsk_pkg::*;

    cfg_t                 cfg;
    logic                 adv;
    logic                 geo_valid;
    item_t                geo_item;
    logic [DIV_NUM_W-1:0] geo_num_x;
    logic [DIV_NUM_W-1:0] geo_num_y;
    logic                 div_valid;
    item_t                div_item;
    logic [DIV_NUM_W-1:0] div_quo_x;
    logic [DIV_NUM_W-1:0] div_quo_y;

    // The pipeline moves unless a finished result is waiting on a stalled
    // consumer. A result taken this cycle frees room for a new transaction.
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    sbsk_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Scaled size, origin offsets and the clip test.
    sbsk_geom #(
        .MAX_SPRITE_W (MAX_SPRITE_W),
        .MAX_SPRITE_H (MAX_SPRITE_H)
    ) u_geom (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .op        (op),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .pixel_in  (pixel_in),
        .out_valid (geo_valid),
        .out_item  (geo_item),
        .out_num_x (geo_num_x),
        .out_num_y (geo_num_y)
    );

    // Screen offset back to sprite coordinates: offset*256/zoom.
    sbsk_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .divisor   (cfg.zoom_factor),
        .in_valid  (geo_valid),
        .in_item   (geo_item),
        .in_num_x  (geo_num_x),
        .in_num_y  (geo_num_y),
        .out_valid (div_valid),
        .out_item  (div_item),
        .out_quo_x (div_quo_x),
        .out_quo_y (div_quo_y)
    );

    // Clamp, mirror, store access and color key.
    sbsk_fetch #(
        .MAX_SPRITE_W (MAX_SPRITE_W),
        .MAX_SPRITE_H (MAX_SPRITE_H)
    ) u_fetch (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .cfg          (cfg),
        .in_valid     (div_valid),
        .in_item      (div_item),
        .in_quo_x     (div_quo_x),
        .in_quo_y     (div_quo_y),
        .out_valid    (out_valid),
        .write_enable (write_enable),
        .pixel_out    (pixel_out),
        .inside_rect  (inside_rect)
    );

`ifndef SYNTH
    // Back-pressure on the input only ever comes from a held result.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // A write is only requested for an inside pixel that is not the key.
    a_write_keyed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_enable) |-> (inside_rect && (pixel_out != KEY_COLOR)))
        else $error("write requested for an outside or transparent pixel");

    // Results outside the rectangle, and load results, carry no pixel.
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !inside_rect) |-> (!write_enable && (pixel_out == 8'd0)))
        else $error("outside result carries pixel data");

    // A frozen pipeline keeps presenting the same result.
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(pixel_out)
                                      && $stable(inside_rect)))
        else $error("held result changed during a stall");
`endif

endmodule

`default_nettype wire
